### src/mh64_pkg.sv
// Package for the 64-bit murmur hash core: mixing constants and sequencer states.
// Used by mh64_mix_unit and murmur_hash_64b_core; depends on nothing else.

package mh64_pkg;

    // Multiplier shared by every mixing step.
    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;

    // Right shift used in the word mix.
    localparam int unsigned WORD_SHIFT = 24;

    // Right shifts of the four cross-mix rounds.
    localparam int unsigned FIN_SHIFT_1 = 18;
    localparam int unsigned FIN_SHIFT_2 = 22;
    localparam int unsigned FIN_SHIFT_3 = 17;
    localparam int unsigned FIN_SHIFT_4 = 19;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY1,
        ST_KEY2,
        ST_KEY3,
        ST_TAIL,
        ST_FIN1,
        ST_FIN2,
        ST_FIN3,
        ST_FIN4
    } state_t;

    // Operands presented to the shared mixing unit.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] fold;
    } mix_op_t;

endpackage

### src/mh64_mix_unit.sv
// Shared mixing unit: (base xor fold) times the murmur multiplier, modulo 2^32.
// Depends on mh64_pkg for the multiplier constant and the operand struct.

module mh64_mix_unit (
    input  mh64_pkg::mix_op_t op,
    output logic [31:0]       product
);

    logic [31:0] operand;

    // One 32 by 32 multiply; only the low word is kept.
    assign operand = op.base ^ op.fold;
    assign product = operand * mh64_pkg::MIX_MUL;

endmodule

### src/murmur_hash_64b_core.sv
// Top level of the 64-bit murmur hash core: sequencer, lanes and output register.
// Depends on mh64_pkg and mh64_mix_unit.
//
//  Channel   Direction  Handshake               Payload
//  key       in         key_valid / key_ready   key_word, word_bytes, first_word,
//                                               last_word, key_length
//  hash      out        hash_valid / hash_ready hash_value
//  cfg       in         cfg_wr_en               cfg_wr_data (hash seed)
//
// A full word takes the request state and three multiplies, a partial word the
// request state and one multiply, an empty word the request state alone; a last
// word adds the cross-mix rounds. Every step uses the single shared multiplier.
// Reset clears the lanes, the word parity, the seed and the output valid.
// A finished hash waits in the output register while the next request is taken;
// only the final mix step stalls if that register is still full.

module murmur_hash_64b_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,

    input  logic        key_valid,
    output logic        key_ready,
    input  logic [31:0] key_word,
    input  logic [2:0]  word_bytes,
    input  logic        first_word,
    input  logic        last_word,
    input  logic [30:0] key_length,

    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [63:0] hash_value
);

    mh64_pkg::state_t  state_reg, state_next;
    mh64_pkg::mix_op_t mix_op;

    logic [31:0] seed_reg;
    logic [31:0] lane_a_reg, lane_a_next;
    logic [31:0] lane_b_reg, lane_b_next;
    logic        parity_reg, parity_next;
    logic        last_reg;
    logic        hash_valid_reg, hash_valid_next;
    logic [63:0] hash_reg;
    logic [31:0] word_reg;
    logic [1:0]  nbytes_reg;
    logic [31:0] k_reg;
    logic [31:0] fa_reg;
    logic [31:0] fb_reg;
    logic [31:0] tail_word;
    logic [31:0] product;
    logic        key_req;
    logic        out_load;

    assign key_req  = key_valid && key_ready;
    assign out_load = (state_reg == mh64_pkg::ST_FIN4) && (!hash_valid_reg || hash_ready);

    // Bytes of a partial word that belong to the key.
    always_comb
    begin
        case (nbytes_reg)
            2'd1:    tail_word = {24'd0, word_reg[7:0]};
            2'd2:    tail_word = {16'd0, word_reg[15:0]};
            2'd3:    tail_word = {8'd0, word_reg[23:0]};
            default: tail_word = 32'd0;
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mh64_pkg::ST_IDLE:
            begin
                if (key_valid)
                begin
                    if (word_bytes[2])
                        state_next = mh64_pkg::ST_KEY1;
                    else if (word_bytes != 3'd0)
                        state_next = mh64_pkg::ST_TAIL;
                    else if (last_word)
                        state_next = mh64_pkg::ST_FIN1;
                end
            end
            mh64_pkg::ST_KEY1: state_next = mh64_pkg::ST_KEY2;
            mh64_pkg::ST_KEY2: state_next = mh64_pkg::ST_KEY3;
            mh64_pkg::ST_KEY3,
            mh64_pkg::ST_TAIL:
                state_next = last_reg ? mh64_pkg::ST_FIN1 : mh64_pkg::ST_IDLE;
            mh64_pkg::ST_FIN1: state_next = mh64_pkg::ST_FIN2;
            mh64_pkg::ST_FIN2: state_next = mh64_pkg::ST_FIN3;
            mh64_pkg::ST_FIN3: state_next = mh64_pkg::ST_FIN4;
            mh64_pkg::ST_FIN4:
            begin
                if (!hash_valid_reg || hash_ready)
                    state_next = mh64_pkg::ST_IDLE;
            end
            default: state_next = mh64_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: ready and the operands of the shared unit.
    always_comb
    begin
        key_ready   = 1'b0;
        mix_op.base = 32'd0;
        mix_op.fold = 32'd0;
        case (state_reg)
            mh64_pkg::ST_IDLE:
                key_ready = 1'b1;
            mh64_pkg::ST_KEY1:
                mix_op.base = word_reg;
            mh64_pkg::ST_KEY2:
            begin
                mix_op.base = k_reg;
                mix_op.fold = k_reg >> mh64_pkg::WORD_SHIFT;
            end
            mh64_pkg::ST_KEY3:
                mix_op.base = parity_reg ? lane_b_reg : lane_a_reg;
            mh64_pkg::ST_TAIL:
            begin
                mix_op.base = lane_b_reg;
                mix_op.fold = tail_word;
            end
            mh64_pkg::ST_FIN1:
            begin
                mix_op.base = lane_a_reg;
                mix_op.fold = lane_b_reg >> mh64_pkg::FIN_SHIFT_1;
            end
            mh64_pkg::ST_FIN2:
            begin
                mix_op.base = lane_b_reg;
                mix_op.fold = fa_reg >> mh64_pkg::FIN_SHIFT_2;
            end
            mh64_pkg::ST_FIN3:
            begin
                mix_op.base = fa_reg;
                mix_op.fold = fb_reg >> mh64_pkg::FIN_SHIFT_3;
            end
            mh64_pkg::ST_FIN4:
            begin
                mix_op.base = fb_reg;
                mix_op.fold = fa_reg >> mh64_pkg::FIN_SHIFT_4;
            end
            default:
                key_ready = 1'b0;
        endcase
    end

    mh64_mix_unit u_mix (
        .op      (mix_op),
        .product (product)
    );

    // Lane and parity updates.
    always_comb
    begin
        lane_a_next = lane_a_reg;
        lane_b_next = lane_b_reg;
        parity_next = parity_reg;
        if (key_req && first_word)
        begin
            lane_a_next = seed_reg ^ {1'b0, key_length};
            lane_b_next = 32'd0;
            parity_next = 1'b0;
        end
        else if (state_reg == mh64_pkg::ST_KEY3)
        begin
            if (parity_reg)
                lane_b_next = product ^ k_reg;
            else
                lane_a_next = product ^ k_reg;
            parity_next = ~parity_reg;
        end
        else if (state_reg == mh64_pkg::ST_TAIL)
        begin
            lane_b_next = product;
        end
    end

    // Output valid: set when a hash is loaded, cleared when it is taken.
    always_comb
    begin
        if (out_load)
            hash_valid_next = 1'b1;
        else if (hash_ready)
            hash_valid_next = 1'b0;
        else
            hash_valid_next = hash_valid_reg;
    end

    // Control state and lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mh64_pkg::ST_IDLE;
            seed_reg       <= 32'd0;
            lane_a_reg     <= 32'd0;
            lane_b_reg     <= 32'd0;
            parity_reg     <= 1'b0;
            last_reg       <= 1'b0;
            hash_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lane_a_reg     <= lane_a_next;
            lane_b_reg     <= lane_b_next;
            parity_reg     <= parity_next;
            hash_valid_reg <= hash_valid_next;
            if (cfg_wr_en)
                seed_reg <= cfg_wr_data;
            if (key_req)
                last_reg <= last_word;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        if (key_req)
        begin
            word_reg   <= key_word;
            nbytes_reg <= word_bytes[1:0];
        end
        if (state_reg == mh64_pkg::ST_KEY1 || state_reg == mh64_pkg::ST_KEY2)
            k_reg <= product;
        if (state_reg == mh64_pkg::ST_FIN1 || state_reg == mh64_pkg::ST_FIN3)
            fa_reg <= product;
        if (state_reg == mh64_pkg::ST_FIN2)
            fb_reg <= product;
        if (out_load)
            hash_reg <= {fa_reg, product};
    end

    assign hash_valid = hash_valid_reg;
    assign hash_value = hash_reg;

endmodule

### src/mh64_checker.sv
// Port-level checker for murmur_hash_64b_core, bound to every instance.
// Depends only on the top level's port list.

module mh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        key_valid,
    input logic        key_ready,
    input logic [2:0]  word_bytes,
    input logic        last_word,
    input logic        hash_valid,
    input logic        hash_ready,
    input logic [63:0] hash_value
);

    // A waiting hash holds its value until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_valid && !hash_ready |=> hash_valid && $stable(hash_value))
        else $error("hash result changed while stalled");

    // The core is busy in the cycle after it takes a word with bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && (word_bytes != 3'd0) |=> !key_ready)
        else $error("request taken during word processing");

    // An empty, non-final word leaves the core ready again in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        key_valid && key_ready && (word_bytes == 3'd0) && !last_word |=> key_ready)
        else $error("empty word stalled the core");

    // A fresh hash appears only as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hash_valid) |-> key_ready)
        else $error("hash appeared while still busy");

endmodule

bind murmur_hash_64b_core mh64_checker u_mh64_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_valid  (key_valid),
    .key_ready  (key_ready),
    .word_bytes (word_bytes),
    .last_word  (last_word),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .hash_value (hash_value)
);
